@@ rtl/bmmd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared types, codes and helper functions for the banked memory map decoder.
// ----------------------------------------------------------------------------
package bmmd_pkg;

  // Width of the physical RAM offset (17..21); offset sums wrap at this width.
  localparam int PhysAddrBits = 21;
  localparam int PhysW        = 21;

  localparam logic [13:0] RomMax    = 14'h3800;
  localparam logic [15:0] RamBase   = 16'h4000;
  localparam logic [15:0] KbdBase   = 16'h3800;
  localparam logic [15:0] VidBase   = 16'h3c00;
  localparam logic [15:0] KbdHiBase = 16'hf400;
  localparam logic [15:0] VidHiBase = 16'hf800;
  localparam logic [PhysAddrBits-1:0] HalfSpan = PhysAddrBits'(32'h8000);

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_MAP    = 3'd2,
    OP_BANK   = 3'd3,
    OP_BASE   = 3'd4,
    OP_VPAGE  = 3'd5,
    OP_ROMIN  = 3'd6,
    OP_NOP    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    RG_RAM  = 3'd0,
    RG_ROM  = 3'd1,
    RG_VID  = 3'd2,
    RG_KBD  = 3'd3,
    RG_NONE = 3'd4
  } region_e;

  typedef enum logic [2:0] {
    BCMD_DIRECT   = 3'd0,
    BCMD_HI_BELOW = 3'd2,
    BCMD_HI_BASE  = 3'd3,
    BCMD_LO_BASE  = 3'd6,
    BCMD_LO_ABOVE = 3'd7
  } bank_cmd_e;

  typedef enum logic [1:0] {
    EXP_NONE  = 2'd0,
    EXP_PORT  = 2'd1,
    EXP_PAGED = 2'd2
  } exp_kind_e;

  typedef enum logic [2:0] {
    MDL_3  = 3'd3,
    MDL_4  = 3'd4,
    MDL_4P = 3'd5
  } model_e;

  typedef enum logic [1:0] {
    CFG_MODEL   = 2'd0,
    CFG_ROM_LEN = 2'd1,
    CFG_EXP     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  model;
    logic [13:0] rom_length;
    logic [1:0]  exp_kind;
  } bmmd_cfg_t;

  typedef struct packed {
    logic [1:0]              map_sel;
    logic                    rom_in;
    logic [2:0]              bank_cmd;
    logic [20:0]             bank_origin;
    logic [PhysAddrBits-1:0] lo_off;
    logic [PhysAddrBits-1:0] hi_off;
    logic                    video_page;
  } bmmd_state_t;

  typedef struct packed {
    logic [2:0]       region;
    logic [PhysW-1:0] phys;
    logic [7:0]       read_value;
    logic             error;
  } bmmd_result_t;

  typedef struct packed {
    logic                    ok;
    logic [PhysAddrBits-1:0] lo;
    logic [PhysAddrBits-1:0] hi;
  } bank_off_t;

  function automatic logic map_legal(logic [2:0] model, logic [7:0] sel, logic rin);
    logic ok;
    ok = 1'b0;
    if (sel <= 8'd3) begin
      case (model)
        MDL_3:   ok = (sel == 8'd0) && !rin;
        MDL_4:   ok = !rin;
        MDL_4P:  ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  // Half-space relocation offsets for a bank command and base.
  function automatic bank_off_t bank_offsets(logic [2:0] cmd, logic [20:0] base);
    bank_off_t r;
    logic [PhysAddrBits-1:0] b;
    b    = base[PhysAddrBits-1:0];
    r.ok = 1'b1;
    r.lo = '0;
    r.hi = '0;
    case (cmd)
      BCMD_DIRECT:   ;
      BCMD_HI_BELOW: r.hi = b - HalfSpan;
      BCMD_HI_BASE:  r.hi = b;
      BCMD_LO_BASE:  r.lo = b;
      BCMD_LO_ABOVE: r.lo = b + HalfSpan;
      default:       r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bmmd_state.sv @@
// ----------------------------------------------------------------------------
// bmmd_state
// Configuration registers and the persistent map/bank state.
// ----------------------------------------------------------------------------
module bmmd_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [13:0]          cfg_data_i,
  input  logic                 upd_en_i,
  input  bmmd_pkg::bmmd_state_t st_d_i,
  output bmmd_pkg::bmmd_state_t st_q_o,
  output bmmd_pkg::bmmd_cfg_t   cfg_q_o
);
  import bmmd_pkg::*;

  bmmd_state_t st_q;
  bmmd_cfg_t   cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.map_sel     <= '0;
      st_q.rom_in      <= 1'b0;
      st_q.bank_cmd    <= BCMD_DIRECT;
      st_q.bank_origin <= 21'h10000;
      st_q.lo_off      <= '0;
      st_q.hi_off      <= '0;
      st_q.video_page  <= 1'b0;
    end else if (upd_en_i) begin
      st_q <= st_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model      <= MDL_4;
      cfg_q.rom_length <= 14'd14336;
      cfg_q.exp_kind   <= EXP_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODEL:   cfg_q.model      <= cfg_data_i[2:0];
        CFG_ROM_LEN: cfg_q.rom_length <= cfg_data_i;
        CFG_EXP:     cfg_q.exp_kind   <= cfg_data_i[1:0];
        default:     ; // drop writes beyond the register list
      endcase
    end
  end

  assign st_q_o  = st_q;
  assign cfg_q_o = cfg_q;

endmodule

@@ rtl/bmmd_decode.sv @@
// ----------------------------------------------------------------------------
// bmmd_decode
// Single-pass decode of one operation: result fields and next state.
// ----------------------------------------------------------------------------
module bmmd_decode (
  input  logic [2:0]             op_i,
  input  logic [15:0]            addr_i,
  input  logic [7:0]             data_i,
  input  bmmd_pkg::bmmd_state_t  st_i,
  input  bmmd_pkg::bmmd_cfg_t    cfg_i,
  output bmmd_pkg::bmmd_state_t  st_d_o,
  output bmmd_pkg::bmmd_result_t res_o
);
  import bmmd_pkg::*;

  logic [13:0]             romlen;
  logic                    rd;
  logic                    rom_hit;
  logic [PhysAddrBits-1:0] ram_off;
  logic [PhysAddrBits-1:0] ram_phys;
  logic [10:0]             vid_phys;
  logic [10:0]             vid_hi_phys;
  logic [5:0]              paged_sum;
  logic [20:0]             new_base;
  logic [3:0]              model_lo;
  bank_off_t               cmd_off;
  bank_off_t               base_off;

  always_comb begin
    romlen      = (cfg_i.rom_length > RomMax) ? RomMax : cfg_i.rom_length;
    rd          = (op_i == OP_READ);
    rom_hit     = rd && (addr_i < {2'b00, romlen});
    ram_off     = addr_i[15] ? st_i.hi_off : st_i.lo_off;
    ram_phys    = PhysAddrBits'(addr_i) + ram_off;
    vid_phys    = 11'(addr_i - VidBase) + {st_i.video_page, 10'd0};
    vid_hi_phys = 11'(addr_i - VidHiBase);
    paged_sum   = {1'b0, data_i[4:1], 1'b0} + 6'd2;
    new_base    = (cfg_i.exp_kind == EXP_PORT) ? {data_i[4:0], 16'd0}
                                                : {paged_sum, 15'd0};
    model_lo    = {1'b0, st_i.rom_in, st_i.map_sel};
    cmd_off     = bank_offsets(data_i[2:0], st_i.bank_origin);
    base_off    = bank_offsets(st_i.bank_cmd, new_base);

    st_d_o           = st_i;
    res_o.region     = RG_NONE;
    res_o.phys       = '0;
    res_o.read_value = '0;
    res_o.error      = 1'b0;

    case (op_i)
      OP_READ, OP_WRITE: begin
        if (!map_legal(cfg_i.model, {6'd0, st_i.map_sel}, st_i.rom_in)) begin
          res_o.error = 1'b1;
        end else if (cfg_i.model == MDL_3 && model_lo == 4'h0) begin
          // Legacy map: RAM unrelocated above the low 16K.
          if (addr_i >= RamBase) begin
            res_o.region = RG_RAM;
            res_o.phys   = PhysW'(addr_i);
          end else if (rom_hit) begin
            res_o.region = RG_ROM;
            res_o.phys   = PhysW'(addr_i);
          end else if (addr_i >= VidBase) begin
            res_o.region = RG_VID;
            res_o.phys   = PhysW'(vid_phys);
          end else if (rd && addr_i >= KbdBase) begin
            res_o.region = RG_KBD;
            res_o.phys   = PhysW'(addr_i[9:0]);
          end
        end else if ((cfg_i.model == MDL_4 && model_lo == 4'h0) ||
                     (!rd && cfg_i.model == MDL_4P && st_i.map_sel == 2'd0)) begin
          if (addr_i >= RamBase) begin
            res_o.region = RG_RAM;
            res_o.phys   = PhysW'(ram_phys);
          end else if (rom_hit) begin
            res_o.region = RG_ROM;
            res_o.phys   = PhysW'(addr_i);
          end else if (addr_i >= VidBase) begin
            res_o.region = RG_VID;
            res_o.phys   = PhysW'(vid_phys);
          end else if (rd && addr_i >= KbdBase) begin
            res_o.region = RG_KBD;
            res_o.phys   = PhysW'(addr_i[9:0]);
          end
        end else if (st_i.map_sel == 2'd1 ||
                     (st_i.map_sel == 2'd0 && cfg_i.model == MDL_4P)) begin
          if (st_i.rom_in && rom_hit) begin
            res_o.region = RG_ROM;
            res_o.phys   = PhysW'(addr_i);
          end else if (addr_i >= RamBase || addr_i < KbdBase) begin
            res_o.region = RG_RAM;
            res_o.phys   = PhysW'(ram_phys);
          end else if (addr_i >= VidBase) begin
            res_o.region = RG_VID;
            res_o.phys   = PhysW'(vid_phys);
          end else if (rd) begin
            res_o.region = RG_KBD;
            res_o.phys   = PhysW'(addr_i[9:0]);
          end
        end else if (st_i.map_sel == 2'd2) begin
          if (addr_i < KbdHiBase) begin
            res_o.region = RG_RAM;
            res_o.phys   = PhysW'(ram_phys);
          end else if (addr_i >= VidHiBase) begin
            res_o.region = RG_VID;
            res_o.phys   = PhysW'(vid_hi_phys);
          end else if (rd) begin
            res_o.region = RG_KBD;
            res_o.phys   = PhysW'(addr_i[9:0]);
          end
        end else begin
          res_o.region = RG_RAM;
          res_o.phys   = PhysW'(ram_phys);
        end
      end
      OP_MAP: begin
        if (map_legal(cfg_i.model, data_i, st_i.rom_in)) begin
          st_d_o.map_sel = data_i[1:0];
        end else begin
          res_o.error = 1'b1;
        end
      end
      OP_BANK: begin
        // The whole byte is the command; anything above seven is unknown.
        if (cmd_off.ok && data_i[7:3] == 5'd0) begin
          st_d_o.bank_cmd = data_i[2:0];
          st_d_o.lo_off   = cmd_off.lo;
          st_d_o.hi_off   = cmd_off.hi;
        end else begin
          res_o.error = 1'b1;
        end
      end
      OP_BASE: begin
        if (addr_i[0]) begin
          res_o.read_value = (cfg_i.exp_kind == EXP_PORT) ?
                             {3'd0, st_i.bank_origin[20:16]} : 8'hFF;
        end else if (cfg_i.exp_kind == EXP_PORT || cfg_i.exp_kind == EXP_PAGED) begin
          // Reload the base and reapply the current bank command.
          st_d_o.bank_origin = new_base;
          st_d_o.lo_off      = base_off.lo;
          st_d_o.hi_off      = base_off.hi;
        end
      end
      OP_VPAGE: st_d_o.video_page = (data_i != 8'd0);
      OP_ROMIN: begin
        if (map_legal(cfg_i.model, {6'd0, st_i.map_sel}, data_i[0])) begin
          st_d_o.rom_in = data_i[0];
        end else begin
          res_o.error = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/banked_memory_map_decoder.sv @@
// ----------------------------------------------------------------------------
// banked_memory_map_decoder
// Maps CPU reads and writes to region and physical offset; handles map, bank,
// video page and ROM-in control operations.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, is decoded in a single pass,
// and is captured in the result register, from which the result handshake is made.
// Throughput: one item per cycle while the receiver does not stall.
// Reset: map select, ROM-in, bank command, offsets and video page clear, bank
// base loads 0x10000, config returns to model 4, ROM length 14336, no
// expansion. Reset takes effect at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] cpu_address_i,
  input  logic [7:0]  data_byte_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  region_o,
  output logic [20:0] phys_address_o,
  output logic [7:0]  read_value_o,
  output logic        error_flag_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  import bmmd_pkg::*;

  // Input register stage.
  logic        in_valid_q;
  logic [2:0]  op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;

  // Result register stage.
  logic         out_valid_q;
  bmmd_result_t res_q;
  bmmd_result_t res_d;

  bmmd_state_t st_q;
  bmmd_state_t st_d;
  bmmd_cfg_t   cfg_q;

  logic out_load;   // result register free or being drained this cycle
  logic advance;    // item in the input register moves into the result register
  logic in_fire;

  assign out_load   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_load;
  assign in_ready_o = !in_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // Take configuration writes at once; send them only while no item is in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload holds while the input register is stalled.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      addr_q <= cpu_address_i;
      data_q <= data_byte_i;
    end
  end

  // Decode one item against the current state; the state commits only when
  // the item advances, so the next item always sees the updated state.
  bmmd_decode u_decode (
    .op_i   (op_q),
    .addr_i (addr_q),
    .data_i (data_q),
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .st_d_o (st_d),
    .res_o  (res_d)
  );

  bmmd_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .upd_en_i    (advance),
    .st_d_i      (st_d),
    .st_q_o      (st_q),
    .cfg_q_o     (cfg_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign region_o       = res_q.region;
  assign phys_address_o = res_q.phys;
  assign read_value_o   = res_q.read_value;
  assign error_flag_o   = res_q.error;

endmodule

@@ rtl/bmmd_checker.sv @@
// ----------------------------------------------------------------------------
// bmmd_checker
// Port-level checks for the banked memory map decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bmmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  region_o,
  input logic [20:0] phys_address_o,
  input logic [7:0]  read_value_o,
  input logic        error_flag_o
);
  import bmmd_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(region_o) &&
    $stable(phys_address_o) && $stable(read_value_o) && $stable(error_flag_o))
    else $error("stalled result changed");

  // An error never comes with a mapped region.
  a_err_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> region_o == RG_NONE && read_value_o == 8'd0)
    else $error("error flag with mapped region");

  // Unmapped results carry no offset.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o == RG_NONE |-> phys_address_o == '0)
    else $error("unmapped result with nonzero offset");

  // A readback value only appears on a non-access, error-free result.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != 8'd0 |-> region_o == RG_NONE && !error_flag_o)
    else $error("readback value on an access");

  // With the result side draining, the input side never stalls.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the banked memory map decoder. Every accepted item
// is run through an in-bench copy of the decode rules; each result item is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmmd_pkg::*;

  // Two register stages between input accept and result valid.
  localparam int DecodeLatency = 2;
  // Watchdog: cycles with no handshake on any channel before giving up.
  localparam int StuckLimit    = 2000;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HoldOffCycles = 150;
  localparam logic [1:0] CfgSpare = 2'd3;

  // Map codes: model in the upper nibble, ROM-in at bit 2, map select below.
  localparam logic [7:0] MapM3     = 8'h30;
  localparam logic [7:0] MapM4     = 8'h40;
  localparam logic [7:0] MapM4P    = 8'h50;
  localparam logic [7:0] MapM4PRom = 8'h54;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [2:0]  operation_i   = OP_NOP;
  logic [15:0] cpu_address_i = '0;
  logic [7:0]  data_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [2:0]  region_o;
  logic [20:0] phys_address_o;
  logic [7:0]  read_value_o;
  logic        error_flag_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [13:0] cfg_data_i    = '0;

  banked_memory_map_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .cpu_address_i  (cpu_address_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .region_o       (region_o),
    .phys_address_o (phys_address_o),
    .read_value_o   (read_value_o),
    .error_flag_o   (error_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decode state mirror: configuration plus the block's map and bank state.
  // --------------------------------------------------------------------------
  logic [2:0]  cur_model     = MDL_4;
  logic [13:0] cur_rom_len   = 14'd14336;
  logic [1:0]  cur_exp       = EXP_NONE;
  logic [1:0]  map_sel_q     = '0;
  logic        rom_in_q      = 1'b0;
  logic [2:0]  bank_cmd_q    = BCMD_DIRECT;
  logic [20:0] bank_origin_q = 21'h10000;
  logic [20:0] lo_off_q      = '0;
  logic [21:0] hi_off_q      = '0;
  logic        video_page_q  = 1'b0;

  bmmd_result_t pending_decodes[$];
  int unsigned  fail_count   = 0;
  int unsigned  result_count = 0;
  int unsigned  stuck_cycles = 0;
  bit           src_jitter   = 1'b1;
  bit           sink_jitter  = 1'b1;
  bit           hold_off_req = 1'b0;

  function automatic logic map_allowed(logic [2:0] model, logic [7:0] sel, logic rin);
    if (sel > 8'd3) return 1'b0;
    if (model == MDL_3) return (sel == 8'd0) && !rin;
    if (model == MDL_4) return !rin;
    return model == MDL_4P;
  endfunction

  // Recompute both half offsets for a bank command; refuse unknown commands.
  function automatic logic rebank(logic [2:0] cmd);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] base;
    base = 32'(bank_origin_q);
    lo   = '0;
    hi   = '0;
    case (cmd)
      BCMD_DIRECT:   ;
      BCMD_HI_BELOW: hi = base - 32'h8000;
      BCMD_HI_BASE:  hi = base;
      BCMD_LO_BASE:  lo = base;
      BCMD_LO_ABOVE: lo = base + 32'h8000;
      default:       return 1'b0;
    endcase
    lo_off_q   = lo[20:0];
    hi_off_q   = hi[21:0];
    bank_cmd_q = cmd;
    return 1'b1;
  endfunction

  function automatic logic [20:0] ram_offset(logic [15:0] a);
    logic [31:0] off;
    off = a[15] ? 32'(hi_off_q) : 32'(lo_off_q);
    return 21'(32'(a) + off);
  endfunction

  function automatic logic [20:0] screen_offset(logic [15:0] a);
    return 21'(32'(a) - 32'(VidBase) + (video_page_q ? 32'd1024 : 32'd0));
  endfunction

  // Predict the result of one item and advance the mirrored state.
  function automatic bmmd_result_t decode_item(logic [2:0] op, logic [15:0] a,
                                               logic [7:0] d);
    bmmd_result_t res;
    logic         rd;
    logic [13:0]  rlen;
    logic [7:0]   m;
    logic [31:0]  page_base;
    res.region     = RG_NONE;
    res.phys       = '0;
    res.read_value = '0;
    res.error      = 1'b0;
    rd   = (op == OP_READ);
    rlen = (cur_rom_len > RomMax) ? RomMax : cur_rom_len;
    m    = {1'b0, cur_model, 1'b0, rom_in_q, map_sel_q};
    case (op)
      OP_READ, OP_WRITE: begin
        if (!map_allowed(cur_model, 8'(map_sel_q), rom_in_q)) begin
          res.error = 1'b1;
        end else if (m == MapM3) begin
          if (a >= RamBase) begin
            res.region = RG_RAM; res.phys = 21'(a);
          end else if (rd && a < 16'(rlen)) begin
            res.region = RG_ROM; res.phys = 21'(a);
          end else if (a >= VidBase) begin
            res.region = RG_VID; res.phys = screen_offset(a);
          end else if (rd && a >= KbdBase) begin
            res.region = RG_KBD; res.phys = 21'(a[9:0]);
          end
        end else if (m == MapM4 || (!rd && (m == MapM4P || m == MapM4PRom))) begin
          if (a >= RamBase) begin
            res.region = RG_RAM; res.phys = ram_offset(a);
          end else if (rd && a < 16'(rlen)) begin
            res.region = RG_ROM; res.phys = 21'(a);
          end else if (a >= VidBase) begin
            res.region = RG_VID; res.phys = screen_offset(a);
          end else if (rd && a >= KbdBase) begin
            res.region = RG_KBD; res.phys = 21'(a[9:0]);
          end
        end else if (map_sel_q == 2'd1 || (map_sel_q == 2'd0 && cur_model == MDL_4P)) begin
          // RAM everywhere but the keyboard/video window, ROM on top if enabled
          if (rd && rom_in_q && a < 16'(rlen)) begin
            res.region = RG_ROM; res.phys = 21'(a);
          end else if (a >= RamBase || a < KbdBase) begin
            res.region = RG_RAM; res.phys = ram_offset(a);
          end else if (a >= VidBase) begin
            res.region = RG_VID; res.phys = screen_offset(a);
          end else if (rd) begin
            res.region = RG_KBD; res.phys = 21'(a[9:0]);
          end
        end else if (map_sel_q == 2'd2) begin
          // keyboard and video moved to the top of the space
          if (a < KbdHiBase) begin
            res.region = RG_RAM; res.phys = ram_offset(a);
          end else if (a >= VidHiBase) begin
            res.region = RG_VID; res.phys = 21'(a - VidHiBase);
          end else if (rd) begin
            res.region = RG_KBD; res.phys = 21'(a[9:0]);
          end
        end else begin
          res.region = RG_RAM; res.phys = ram_offset(a);
        end
      end
      OP_MAP: begin
        if (map_allowed(cur_model, d, rom_in_q)) map_sel_q = d[1:0];
        else res.error = 1'b1;
      end
      OP_BANK: begin
        // a byte above seven is an unknown command and leaves the banks alone
        if (d > 8'd7) res.error = 1'b1;
        else if (!rebank(d[2:0])) res.error = 1'b1;
      end
      OP_BASE: begin
        if (a[0]) begin
          res.read_value = (cur_exp == EXP_PORT) ? {3'b0, bank_origin_q[20:16]} : 8'hFF;
        end else if (cur_exp == EXP_PORT) begin
          bank_origin_q = {d[4:0], 16'h0000};
          void'(rebank(bank_cmd_q));
        end else if (cur_exp == EXP_PAGED) begin
          page_base     = (32'(d) & 32'h1E) + 32'd2;
          bank_origin_q = 21'(page_base << 15);
          void'(rebank(bank_cmd_q));
        end
      end
      OP_VPAGE: video_page_q = (d != 8'd0);
      OP_ROMIN: begin
        if (map_allowed(cur_model, 8'(map_sel_q), d[0])) rom_in_q = d[0];
        else res.error = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: check result items first, then record config and new items.
  // Each result is registered after its item is taken, so the order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    bmmd_result_t want;
    if (out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_decodes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with nothing pending", result_count);
      end else begin
        want = pending_decodes.pop_front();
        if (region_o !== want.region || phys_address_o !== want.phys ||
            read_value_o !== want.read_value || error_flag_o !== want.error) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: region %0d/%0d phys %h/%h read %h/%h err %b/%b",
                     result_count, want.region, region_o, want.phys, phys_address_o,
                     want.read_value, read_value_o, want.error, error_flag_o);
        end
      end
    end
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODEL:   cur_model   = cfg_data_i[2:0];
        CFG_ROM_LEN: cur_rom_len = cfg_data_i;
        CFG_EXP:     cur_exp     = cfg_data_i[1:0];
        default:     ;
      endcase
    end
    if (in_valid_i && in_ready_o)
      pending_decodes.push_back(decode_item(operation_i, cpu_address_i, data_byte_i));
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result receiver: ready by default, random stall bursts, or one long
  // hold-off on request. Each decision holds for a counted number of cycles.
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        hold = HoldOffCycles;
        hold_off_req = 1'b0;
      end else if (sink_jitter && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(1, 7);
      end else begin
        out_ready_i <= 1'b1;
        hold = 1;
      end
      repeat (hold) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Item source
  // --------------------------------------------------------------------------
  // Offer one item, maybe after an idle burst, and hold it until accepted.
  task automatic send_item(logic [2:0] op, logic [15:0] a, logic [7:0] d);
    if (src_jitter && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    cpu_address_i <= a;
    data_byte_i   <= d;
    @(posedge clk_i);
    while (!(in_valid_i && in_ready_o)) @(posedge clk_i);
  endtask

  // Drop valid, wait for every prediction to be matched, then let the
  // pipeline empty before anything touches the registers. The first edge
  // lets the scoreboard record the item accepted just before.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (DecodeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
  endtask

  // Write all registers, plus the unused index, which must be ignored.
  task automatic set_config(logic [13:0] model_w, logic [13:0] rom_w, logic [13:0] exp_w);
    settle();
    write_reg(CfgSpare, 14'($urandom));
    write_reg(CFG_MODEL, model_w);
    write_reg(CFG_ROM_LEN, rom_w);
    write_reg(CFG_EXP, exp_w);
    cfg_valid_i <= 1'b0;
  endtask

  // Addresses cluster on region edges and the ROM length; the rest is flat.
  function automatic logic [15:0] pick_address();
    logic [15:0] edge_addr;
    case ($urandom_range(0, 9))
      0:       edge_addr = 16'h0000;
      1:       edge_addr = KbdBase;
      2:       edge_addr = VidBase;
      3:       edge_addr = RamBase;
      4:       edge_addr = 16'h8000;
      5:       edge_addr = KbdHiBase;
      6:       edge_addr = VidHiBase;
      7:       edge_addr = 16'(cur_rom_len);
      default: return 16'($urandom);
    endcase
    return edge_addr + 16'($urandom_range(0, 3)) - 16'd2;
  endfunction

  // Mostly accesses and well-formed control ops, some malformed, some noise.
  task automatic random_item();
    int unsigned pick;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    d    = 8'($urandom);
    if (pick < 28) begin
      send_item(OP_READ, pick_address(), d);
    end else if (pick < 50) begin
      send_item(OP_WRITE, pick_address(), d);
    end else if (pick < 58) begin
      send_item(OP_MAP, 16'($urandom),
                ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : d);
    end else if (pick < 66) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       d = BCMD_DIRECT;
          1:       d = BCMD_HI_BELOW;
          2:       d = BCMD_HI_BASE;
          3:       d = BCMD_LO_BASE;
          default: d = BCMD_LO_ABOVE;
        endcase
      end
      send_item(OP_BANK, 16'($urandom), d);
    end else if (pick < 74) begin
      send_item(OP_BASE, 16'($urandom), d);
    end else if (pick < 80) begin
      send_item(OP_VPAGE, 16'($urandom), ($urandom_range(0, 1) != 0) ? 8'd0 : d);
    end else if (pick < 88) begin
      send_item(OP_ROMIN, 16'($urandom),
                ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 1)) : d);
    end else if (pick < 92) begin
      send_item(OP_NOP, 16'($urandom), d);
    end else begin
      send_item(3'($urandom_range(0, 7)), 16'($urandom), d);
    end
  endtask

  task automatic run_phase(logic [13:0] model_w, logic [13:0] rom_w, logic [13:0] exp_w,
                           int unsigned count);
    set_config(model_w, rom_w, exp_w);
    // clear ROM-in and the map so most of the phase decodes under a legal map
    send_item(OP_ROMIN, 16'h0000, 8'h00);
    send_item(OP_MAP, 16'h0000, 8'h00);
    repeat (count) random_item();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Decode under the reset configuration and reset map.
  task automatic test_default_map();
    send_item(OP_READ, 16'h0000, 8'h00);     // bottom of ROM
    send_item(OP_READ, 16'h3800, 8'hFF);     // keyboard window
    send_item(OP_WRITE, 16'h3C00, 8'h5A);    // first video byte
    send_item(OP_WRITE, 16'h0000, 8'hA5);    // write into ROM is dropped
    send_item(OP_READ, 16'hFFFF, 8'h00);     // top of RAM
    send_item(OP_NOP, 16'hFFFF, 8'hFF);      // unused operation
  endtask

  // Control operations, their error cases, and the maps they select.
  task automatic test_control_ops();
    send_item(OP_MAP, 16'h0000, 8'h04);      // map beyond three
    send_item(OP_BANK, 16'h0000, 8'h01);     // unknown bank command
    send_item(OP_BANK, 16'h0000, BCMD_HI_BASE);
    send_item(OP_READ, 16'h8000, 8'h00);     // upper half relocated
    send_item(OP_BASE, 16'h0000, 8'hFF);     // no expansion: ignored
    send_item(OP_BASE, 16'h0001, 8'h00);     // readback without expansion
    send_item(OP_VPAGE, 16'h0000, 8'h80);    // any nonzero byte: page one
    send_item(OP_READ, 16'h3FFF, 8'h00);
    send_item(OP_ROMIN, 16'h0000, 8'h01);    // ROM-in not allowed on model 4
    send_item(OP_MAP, 16'h0000, 8'h02);
    send_item(OP_READ, 16'hF400, 8'h00);     // high keyboard
    send_item(OP_READ, 16'hF800, 8'h00);     // high video
    send_item(OP_MAP, 16'h0000, 8'h03);
    send_item(OP_READ, 16'h0000, 8'h00);     // all RAM
  endtask

  // Model change under a live map, then the two expansion styles.
  task automatic test_model_changes();
    set_config(14'(MDL_3), 14'd14336, 14'(EXP_NONE));
    send_item(OP_READ, 16'h4000, 8'h00);     // map three now illegal
    set_config(14'(MDL_4P), 14'h3FFF, 14'(EXP_PORT));
    send_item(OP_ROMIN, 16'h0000, 8'h01);
    send_item(OP_MAP, 16'h0000, 8'h00);
    send_item(OP_READ, 16'h37FF, 8'h00);     // oversized ROM length saturates
    send_item(OP_BASE, 16'h0000, 8'hFF);
    send_item(OP_BASE, 16'h0001, 8'h00);
    send_item(OP_BANK, 16'h0000, BCMD_LO_ABOVE);
    send_item(OP_READ, 16'h4000, 8'h00);     // lower half relocated above the base
    set_config(14'(MDL_4P), 14'h3FFF, 14'(EXP_PAGED));
    send_item(OP_BASE, 16'h0000, 8'h00);
    send_item(OP_READ, 16'h4000, 8'h00);
  endtask

  // Random items across several settings, extremes among them.
  task automatic test_random_phases();
    run_phase(14'(MDL_4), 14'd14336, 14'(EXP_PORT), 260);
    run_phase(14'(MDL_4P), 14'h3FFF, 14'(EXP_PAGED), 260);
    run_phase(14'(MDL_3), 14'h0000, 14'(EXP_PORT), 220);
    run_phase(14'(MDL_4P), 14'h1234, 14'h0003, 220);
    run_phase(14'h3FFF, 14'd5000, 14'h3FFE, 100);   // model seven: no legal map
    run_phase(14'h3FF8, 14'd100, 14'(EXP_NONE), 40); // model zero
  endtask

  // Stall the receiver for a long stretch while items keep coming.
  task automatic test_backpressure();
    set_config(14'(MDL_4P), 14'd8192, 14'(EXP_PORT));
    src_jitter   = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) random_item();
    settle();
    src_jitter = 1'b1;
  endtask

  // Last stretch: no idling on either side.
  task automatic test_steady_stream();
    set_config(14'(MDL_4P), 14'd14336, 14'(EXP_PORT));
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    send_item(OP_ROMIN, 16'h0000, 8'h01);
    repeat (260) random_item();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_map();
    test_control_ops();
    test_model_changes();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    settle();
    repeat (DecodeLatency + 4) @(posedge clk_i);
    if (fail_count == 0 && pending_decodes.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ banked_memory_map_decoder.f @@
rtl/bmmd_pkg.sv
rtl/bmmd_state.sv
rtl/bmmd_decode.sv
rtl/banked_memory_map_decoder.sv
rtl/bmmd_checker.sv
tb/tb.sv
